/* src/nor_flash_command_unit_macros.svh */
// ----------------------------------------------------------------------------
// nor_flash_command_unit_macros
// Assertion macros used by the checker file nfcu_checker.sv.
// ----------------------------------------------------------------------------
`ifndef NOR_FLASH_COMMAND_UNIT_MACROS_SVH
`define NOR_FLASH_COMMAND_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define NFCU_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("nfcu: same-cycle check failed");

// next-cycle implication, masked during reset
`define NFCU_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("nfcu: next-cycle check failed");

// next-cycle implication that also holds across reset
`define NFCU_ASSERT_NEXT_ALWAYS(label, pre, post) \
    label: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("nfcu: reset check failed");

`endif

/* src/nfcu_pkg.sv */
// ----------------------------------------------------------------------------
// nfcu_pkg
// Shared constants and types of the NOR flash command unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nfcu_pkg;

    // array size, a power of two
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    localparam logic [15:0] ADDR_FIRST  = 16'h0555;
    localparam logic [15:0] ADDR_SECOND = 16'h02AA;
    localparam logic [15:0] ADDR_MFR_ID = 16'h0000;
    localparam logic [15:0] ADDR_CHIP_ID = 16'h0001;

    localparam logic [7:0] CMD_FIRST      = 8'hAA;
    localparam logic [7:0] CMD_SECOND     = 8'h55;
    localparam logic [7:0] CMD_PROGRAM    = 8'hA0;
    localparam logic [7:0] CMD_AUTOSELECT = 8'h90;

    localparam logic [7:0] ID_MANUFACTURER = 8'h01;
    localparam logic [7:0] ID_CHIP         = 8'h22;
    localparam logic [7:0] ERASED_BYTE     = 8'hFF;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_LOCKED   = 2'd0,
        ST_WAITING  = 2'd1,
        ST_UNLOCKED = 2'd2,
        ST_PROGRAM  = 2'd3
    } t_cmd_state;

    // address wraps modulo the array size
    function automatic logic [MEM_AW-1:0] cell_index(input logic [15:0] addr);
        logic [31:0] wide;
        wide = 32'(addr);
        return wide[MEM_AW-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/nfcu_ram.sv */
// ----------------------------------------------------------------------------
// nfcu_ram
// Generic single-clock RAM, one write port, one read port with registered
// read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/nor_flash_command_unit.sv */
// ----------------------------------------------------------------------------
// nor_flash_command_unit
// Byte-wide NOR flash model with unlock, autoselect and program commands.
//
//   channel  dir  handshake                 beat payload
//   in       in   i_in_valid / o_in_stall   i_action, i_address, i_write_byte
//   out      out  o_out_valid / i_out_stall o_read_data
//
// one access per unstalled cycle; a read shows its byte the cycle after acceptance
// a write gives no beat and updates the command state in its own cycle
// after reset the array is swept to 0xFF while o_in_stall stays high
// a held read beat stalls the input until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module nor_flash_command_unit
    import nfcu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_action,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_data
);

    t_cmd_state        r_state, n_state;
    logic              r_autosel, n_autosel;
    logic              r_clearing;
    logic [MEM_AW-1:0] r_clr_addr;
    logic              r_out_valid;
    logic              r_id_hit;
    logic [7:0]        r_id_byte;

    logic              in_acc;
    logic              rd_acc;
    logic              ram_we;
    logic [MEM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic              prog_we;
    logic              id_hit;
    logic [7:0]        id_byte;

    assign o_in_stall = r_clearing | (r_out_valid & i_out_stall);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign rd_acc     = in_acc & (i_action == ACT_READ);

    always_comb begin
        n_state   = r_state;
        n_autosel = r_autosel;
        prog_we   = 1'b0;
        if (in_acc && i_action == ACT_WRITE) begin
            unique case (r_state)
                ST_LOCKED: begin
                    if (i_address == ADDR_FIRST && i_write_byte == CMD_FIRST) begin
                        n_state = ST_WAITING;
                    end
                end
                ST_WAITING: begin
                    if (i_address == ADDR_SECOND && i_write_byte == CMD_SECOND) begin
                        n_state = ST_UNLOCKED;
                    end
                end
                ST_UNLOCKED: begin
                    if (i_address == ADDR_FIRST && i_write_byte == CMD_AUTOSELECT) begin
                        n_autosel = 1'b1;
                    end
                    if (i_address == ADDR_FIRST && i_write_byte == CMD_PROGRAM) begin
                        n_state = ST_PROGRAM;
                    end
                end
                ST_PROGRAM: begin
                    prog_we = 1'b1;
                    n_state = ST_LOCKED;
                end
                default: begin
                    n_state = ST_LOCKED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOCKED;
            r_autosel <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_autosel <= n_autosel;
        end
    end

    // erase sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {MEM_AW{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign ram_we    = r_clearing | prog_we;
    assign ram_waddr = r_clearing ? r_clr_addr : cell_index(i_address);
    assign ram_wdata = r_clearing ? ERASED_BYTE : i_write_byte;

    nfcu_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_array (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_acc),
        .i_raddr (cell_index(i_address)),
        .o_rdata (ram_rdata)
    );

    // id bytes override the array at addresses 0x0000 and 0x0001 in autoselect mode
    always_comb begin
        id_hit  = 1'b0;
        id_byte = ID_MANUFACTURER;
        if (r_autosel && i_address == ADDR_MFR_ID) begin
            id_hit  = 1'b1;
            id_byte = ID_MANUFACTURER;
        end else if (r_autosel && i_address == ADDR_CHIP_ID) begin
            id_hit  = 1'b1;
            id_byte = ID_CHIP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!(r_out_valid && i_out_stall)) begin
            r_out_valid <= rd_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_acc) begin
            r_id_hit  <= id_hit;
            r_id_byte <= id_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_id_hit ? r_id_byte : ram_rdata;

endmodule

`default_nettype wire

/* src/nfcu_checker.sv */
// ----------------------------------------------------------------------------
// nfcu_checker
// Port-level checks of the NOR flash command unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nor_flash_command_unit_macros.svh"

module nfcu_checker
    import nfcu_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_action,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_read_data
);

    logic rd_acc;
    logic wr_acc;

    assign rd_acc = i_in_valid & ~o_in_stall & (i_action == ACT_READ);
    assign wr_acc = i_in_valid & ~o_in_stall & (i_action == ACT_WRITE);

    // a held beat keeps its byte
    `NFCU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_data))
    // every accepted read raises o_out_valid on the next cycle
    `NFCU_ASSERT_NEXT(a_read_beat, rd_acc, o_out_valid)
    // a write never gives a beat
    `NFCU_ASSERT_NEXT(a_write_silent, wr_acc, !o_out_valid)
    // a held beat blocks the input side
    `NFCU_ASSERT_NOW(a_hold_stalls, o_out_valid && i_out_stall, o_in_stall)
    // erase sweep keeps the input stalled right after reset
    `NFCU_ASSERT_NEXT_ALWAYS(a_reset_sweep, !i_rst_n, o_in_stall && !o_out_valid)

endmodule

bind nor_flash_command_unit nfcu_checker u_nfcu_checker (.*);

`default_nettype wire
